// ===== src/m3inv_pkg.sv =====
//------------------------------------------------------------------------------
// m3inv_pkg: shared constants for the 3x3 matrix inverse
// Default widths and fixed-point format used by the top-level block and the bench.
//------------------------------------------------------------------------------
package m3inv_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
endpackage

// ===== src/m3inv_if.sv =====
//------------------------------------------------------------------------------
// m3inv_if: valid/ready channel carrying nine matrix elements
// Used for both the input matrix and the inverse result.
//------------------------------------------------------------------------------
interface m3inv_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic                         singular;
    logic                         saturated;

    modport source (output valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                    singular, saturated, input ready);
    modport sink   (input valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                    singular, saturated, output ready);
endinterface

// ===== src/m3inv_div.sv =====
//------------------------------------------------------------------------------
// m3inv_div: pipelined restoring divider, one quotient bit per stage
// Divides |num| by |den|, truncates toward zero and saturates to DATA_WIDTH.
//------------------------------------------------------------------------------
module m3inv_div #(
    parameter int DATA_WIDTH = 32,
    parameter int NW = 66,
    parameter int DW = 99
) (
    input  logic                         clk,
    input  logic                         adv,
    input  logic [NW-1:0]                num,
    input  logic [DW-1:0]                den,
    input  logic                         neg,
    output logic signed [DATA_WIDTH-1:0] quo,
    output logic                         sat
);
    // quotient bits needed: NW-bit dividend, saturation detected from those
    localparam int QB = NW;
    logic [DW:0]   rem_reg  [QB+1];
    logic [NW-1:0] num_reg  [QB+1];
    logic [QB-1:0] q_reg    [QB+1];
    logic [DW-1:0] den_reg  [QB+1];
    logic          neg_reg  [QB+1];

    always_comb
    begin
        rem_reg[0] = '0;
        num_reg[0] = num;
        q_reg[0]   = '0;
        den_reg[0] = den;
        neg_reg[0] = neg;
    end

    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic [DW:0] trial;
        logic [DW:0] sub;
        assign trial = {rem_reg[s][DW-1:0], num_reg[s][NW-1-s]};
        assign sub   = trial - {1'b0, den_reg[s]};
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s+1] <= sub[DW] ? trial : sub;
                q_reg[s+1]   <= {q_reg[s][QB-2:0], ~sub[DW]};
                num_reg[s+1] <= num_reg[s];
                den_reg[s+1] <= den_reg[s];
                neg_reg[s+1] <= neg_reg[s];
            end
        end
    end

    localparam logic [QB-1:0] LIM = QB'(1) << (DATA_WIDTH-1);
    logic [QB-1:0] qf;
    assign qf = q_reg[QB];
    always_comb
    begin
        if (neg_reg[QB])
        begin
            sat = qf > LIM;
            quo = sat ? DATA_WIDTH'(LIM) : DATA_WIDTH'(-qf);
        end
        else
        begin
            sat = qf > (LIM - QB'(1));
            quo = sat ? DATA_WIDTH'(LIM - QB'(1)) : DATA_WIDTH'(qf);
        end
    end
endmodule

// ===== src/matrix3x3_inverse.sv =====
//------------------------------------------------------------------------------
// matrix3x3_inverse: streaming 3x3 fixed-point matrix inverse by adjugate
// Cofactors, determinant, then nine parallel pipelined dividers.
//------------------------------------------------------------------------------
// Usage:
//   in  : one matrix per beat, nine signed fixed-point elements (e00..e22).
//   out : one inverse per beat, nine saturated elements plus the singular
//         and saturated flags (input-side flags are ignored).
// A zero determinant gives all-zero elements with singular set.
// Throughput: one matrix per cycle while the receiver keeps ready high.
// The restoring divider sets the pipe depth: it resolves one quotient bit per
//   stage over the full width of the shifted cofactor magnitude, which is
//   2*DATA_WIDTH + 2*FRAC_BITS + 1 bits wide (97 bits for Q16.16).
// Stages: products of element pairs, cofactor differences, split determinant
//   products, determinant terms, determinant sum and sign removal, then the
//   divider stages.
// Stall: the whole pipe advances on a common enable; when the receiver holds
//   ready low with a valid result at the output, every stage holds. An empty
//   output stage never holds the pipe: ready stays high while it is empty.
// Reset: clears all valid bits; payload registers are not reset.
//------------------------------------------------------------------------------
module matrix3x3_inverse #(
    parameter int DATA_WIDTH = m3inv_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = m3inv_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    m3inv_if.sink   in_ch,
    m3inv_if.source out_ch
);
    import m3inv_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;          // element product
    localparam int CW = 2 * W + 1;      // cofactor
    localparam int HW = 2 * W + 1;      // half of a det term
    localparam int DPW = 3 * W + 1;     // det term
    localparam int DTW = 3 * W + 3;     // determinant
    localparam int NW = 2 * W + 2 * FRAC_BITS + 1; // shifted |cofactor|
    localparam int DEPTH = 5 + NW;

    // pipeline valid bits, shift on common advance
    logic [DEPTH-1:0] vld_reg;
    logic             adv;
    assign adv = !vld_reg[DEPTH-1] || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], in_ch.valid};
    end

    logic signed [W-1:0] m [9];
    assign m[0] = in_ch.e00; assign m[1] = in_ch.e01; assign m[2] = in_ch.e02;
    assign m[3] = in_ch.e10; assign m[4] = in_ch.e11; assign m[5] = in_ch.e12;
    assign m[6] = in_ch.e20; assign m[7] = in_ch.e21; assign m[8] = in_ch.e22;

    // stage 1: 18 element products, keep first column
    localparam int PA [18] = '{4,7, 7,1, 1,4, 6,3, 0,6, 3,0, 3,6, 6,0, 0,3};
    localparam int PB [18] = '{8,5, 2,8, 5,2, 5,8, 8,2, 2,5, 7,4, 1,7, 4,1};
    logic signed [PW-1:0] p_reg [18];
    logic signed [W-1:0]  c0_reg [3];
    logic signed [W-1:0]  c0b_reg [3];

    for (genvar i = 0; i < 18; i++) begin : g_prod
        always_ff @(posedge clk)
        begin
            if (adv)
                p_reg[i] <= PW'(m[PA[i]]) * PW'(m[PB[i]]);
        end
    end

    // stage 2: cofactors
    logic signed [CW-1:0] c_reg [9];
    for (genvar i = 0; i < 9; i++) begin : g_cof
        always_ff @(posedge clk)
        begin
            if (adv)
                c_reg[i] <= CW'(p_reg[2*i]) - CW'(p_reg[2*i+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0_reg  <= '{m[0], m[3], m[6]};
            c0b_reg <= c0_reg;
        end
    end

    // stage 3: split each first-column cofactor at bit W, so every multiplier
    // stays one element wide by one element plus a bit
    logic signed [HW-1:0] dlo_reg [3];
    logic signed [HW-1:0] dhi_reg [3];
    logic signed [CW-1:0] c3_reg [9];
    for (genvar i = 0; i < 3; i++) begin : g_dpp
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dlo_reg[i] <= HW'(c0b_reg[i]) * HW'($signed({1'b0, c_reg[i][W-1:0]}));
                dhi_reg[i] <= HW'(c0b_reg[i]) * HW'($signed(c_reg[i][CW-1:W]));
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            c3_reg <= c_reg;
    end

    // stage 4: recombine the halves into determinant terms
    logic signed [DPW-1:0] dp_reg [3];
    logic signed [CW-1:0]  c4_reg [9];
    for (genvar i = 0; i < 3; i++) begin : g_dp
        always_ff @(posedge clk)
        begin
            if (adv)
                dp_reg[i] <= (DPW'(dhi_reg[i]) <<< W) + DPW'(dlo_reg[i]);
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            c4_reg <= c3_reg;
    end

    // stage 5: determinant sum, magnitudes and signs
    logic signed [DTW-1:0] det;
    logic [DTW-1:0]        dmag;
    assign det  = DTW'(dp_reg[0]) + DTW'(dp_reg[1]) + DTW'(dp_reg[2]);
    assign dmag = det[DTW-1] ? -det : det;

    logic [NW-1:0]  n_reg   [9];
    logic           neg_reg [9];
    logic [DTW-1:0] d_reg;
    logic           zero_reg;
    for (genvar i = 0; i < 9; i++) begin : g_mag
        logic [CW-1:0] cm;
        assign cm = c4_reg[i][CW-1] ? -c4_reg[i] : c4_reg[i];
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                n_reg[i]   <= NW'(cm) << (2 * FRAC_BITS);
                neg_reg[i] <= c4_reg[i][CW-1] ^ det[DTW-1];
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // a zero divisor is replaced by one to keep the divider sane
            d_reg    <= (det == '0) ? DTW'(1) : dmag;
            zero_reg <= (det == '0);
        end
    end

    // divider stages
    logic signed [W-1:0] q   [9];
    logic [8:0]          sat;
    for (genvar i = 0; i < 9; i++) begin : g_div
        m3inv_div #(.DATA_WIDTH(W), .NW(NW), .DW(DTW)) u_div (
            .clk (clk),
            .adv (adv),
            .num (n_reg[i]),
            .den (d_reg),
            .neg (neg_reg[i]),
            .quo (q[i]),
            .sat (sat[i])
        );
    end

    // carry singular flag alongside the divider
    logic [NW-1:0] zero_pipe_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            zero_pipe_reg <= {zero_pipe_reg[NW-2:0], zero_reg};
    end

    logic zf;
    assign zf = zero_pipe_reg[NW-1];
    assign out_ch.valid     = vld_reg[DEPTH-1];
    assign out_ch.e00       = zf ? '0 : q[0];
    assign out_ch.e01       = zf ? '0 : q[1];
    assign out_ch.e02       = zf ? '0 : q[2];
    assign out_ch.e10       = zf ? '0 : q[3];
    assign out_ch.e11       = zf ? '0 : q[4];
    assign out_ch.e12       = zf ? '0 : q[5];
    assign out_ch.e20       = zf ? '0 : q[6];
    assign out_ch.e21       = zf ? '0 : q[7];
    assign out_ch.e22       = zf ? '0 : q[8];
    assign out_ch.singular  = zf;
    assign out_ch.saturated = !zf && (|sat);
endmodule

// ===== bench/matrix3x3_inverse_tb.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// matrix3x3_inverse_tb: self-checking bench for the 3x3 matrix inverse
// Streams directed and random matrices through the block with random idling
// on both channels. It predicts each inverse with exact wide arithmetic and
// checks every output beat, field by field, in order.
//------------------------------------------------------------------------------
module matrix3x3_inverse_tb;
    import m3inv_pkg::*;

    localparam int DW        = DATA_WIDTH_DEF;
    localparam int FB        = FRAC_BITS_DEF;
    localparam int N_RANDOM  = 930;
    localparam int LATENCY   = 5 + 2 * DW + 2 * FB + 1;
    localparam int STUCK_MAX = 4000;
    localparam logic signed [DW-1:0] ONE  = 1 <<< FB;
    localparam logic signed [DW-1:0] EMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] EMIN = {1'b1, {(DW-1){1'b0}}};

    // Wide enough for every cofactor, determinant and shifted numerator.
    typedef logic signed [191:0] exact_t;

    typedef struct {
        logic signed [DW-1:0] e [9];
        bit                   hold_for_drain;
    } matrix_t;

    typedef struct {
        logic signed [DW-1:0] e [9];
        logic                 singular;
        logic                 saturated;
    } inverse_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    m3inv_if #(.DATA_WIDTH(DW)) in_ch ();
    m3inv_if #(.DATA_WIDTH(DW)) out_ch ();

    matrix3x3_inverse #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #6 clk = ~clk;

    matrix_t  pending_mats [$];
    inverse_t expected_invs [$];
    int       fails;
    int       total_mats;
    int       sent_mats;
    int       send_gap;
    int       recv_gap;
    int       stuck_cycles;
    bit       calm;

    assign calm = (sent_mats >= total_mats - 120);

    // Exact inverse by adjugate; quotients truncate toward zero, then clip.
    function automatic inverse_t invert(matrix_t m);
        exact_t   a [9];
        exact_t   cof [9];
        exact_t   det;
        exact_t   q;
        inverse_t r;
        for (int i = 0; i < 9; i++)
        begin
            a[i] = m.e[i];
        end
        cof[0] = a[4] * a[8] - a[7] * a[5];
        cof[1] = a[7] * a[2] - a[1] * a[8];
        cof[2] = a[1] * a[5] - a[4] * a[2];
        cof[3] = a[6] * a[5] - a[3] * a[8];
        cof[4] = a[0] * a[8] - a[6] * a[2];
        cof[5] = a[3] * a[2] - a[0] * a[5];
        cof[6] = a[3] * a[7] - a[6] * a[4];
        cof[7] = a[6] * a[1] - a[0] * a[7];
        cof[8] = a[0] * a[4] - a[3] * a[1];
        det = a[0] * cof[0] + a[3] * cof[1] + a[6] * cof[2];
        r.saturated = 1'b0;
        r.singular  = (det == 0);
        for (int i = 0; i < 9; i++)
        begin
            if (r.singular)
            begin
                r.e[i] = '0;
            end
            else
            begin
                q = (cof[i] <<< (2 * FB)) / det;
                if (q > exact_t'(EMAX))
                begin
                    r.e[i] = EMAX;
                    r.saturated = 1'b1;
                end
                else if (q < exact_t'(EMIN))
                begin
                    r.e[i] = EMIN;
                    r.saturated = 1'b1;
                end
                else
                begin
                    r.e[i] = q[DW-1:0];
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
        fails++;
        $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    endtask

    function automatic matrix_t diag(logic signed [DW-1:0] d0, logic signed [DW-1:0] d1,
                                     logic signed [DW-1:0] d2);
        matrix_t m;
        foreach (m.e[i]) m.e[i] = '0;
        m.e[0] = d0;
        m.e[4] = d1;
        m.e[8] = d2;
        m.hold_for_drain = 1'b0;
        return m;
    endfunction

    function automatic logic signed [DW-1:0] rand_elem(int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            2: return $signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200;
            default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        endcase
    endfunction

    // Random matrix: mostly moderate values that give in-range inverses,
    // with full-range noise and deliberately singular shapes mixed in.
    function automatic matrix_t rand_matrix();
        matrix_t m;
        int      kind;
        int      shape;
        kind  = $urandom_range(0, 9);
        kind  = (kind < 2) ? 0 : (kind < 7) ? 1 : (kind < 8) ? 2 : 3;
        shape = $urandom_range(0, 11);
        foreach (m.e[i]) m.e[i] = rand_elem(kind);
        if (shape == 0)
        begin
            // repeat a row
            m.e[6] = m.e[0];
            m.e[7] = m.e[1];
            m.e[8] = m.e[2];
        end
        else if (shape == 1)
        begin
            // repeat a column
            m.e[2] = m.e[0];
            m.e[5] = m.e[3];
            m.e[8] = m.e[6];
        end
        else if (shape == 2)
        begin
            // shift the diagonal entries by fixed offsets
            m.e[0] = m.e[0] + 32'sh0004_0000;
            m.e[4] = m.e[4] - 32'sh0004_0000;
            m.e[8] = m.e[8] + 32'sh0006_0000;
        end
        m.hold_for_drain = 1'b0;
        return m;
    endfunction

    // Driver: present the oldest pending matrix, with random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.singular  <= 1'b0;
            in_ch.saturated <= 1'b0;
            in_ch.e00 <= '0; in_ch.e01 <= '0; in_ch.e02 <= '0;
            in_ch.e10 <= '0; in_ch.e11 <= '0; in_ch.e12 <= '0;
            in_ch.e20 <= '0; in_ch.e21 <= '0; in_ch.e22 <= '0;
            send_gap  <= 0;
            sent_mats <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_invs.push_back(invert(pending_mats.pop_front()));
                sent_mats <= sent_mats + 1;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    in_ch.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_mats.size() == 0)
                begin
                    in_ch.valid <= 1'b0;
                end
                else if (pending_mats[0].hold_for_drain && expected_invs.size() != 0)
                begin
                    // hold until the pipe has emptied
                    in_ch.valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    in_ch.valid <= 1'b0;
                    send_gap <= $urandom_range(0, 13);
                end
                else
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.e00 <= pending_mats[0].e[0];
                    in_ch.e01 <= pending_mats[0].e[1];
                    in_ch.e02 <= pending_mats[0].e[2];
                    in_ch.e10 <= pending_mats[0].e[3];
                    in_ch.e11 <= pending_mats[0].e[4];
                    in_ch.e12 <= pending_mats[0].e[5];
                    in_ch.e20 <= pending_mats[0].e[6];
                    in_ch.e21 <= pending_mats[0].e[7];
                    in_ch.e22 <= pending_mats[0].e[8];
                end
            end
        end
    end

    // Monitor: check each output beat against the oldest prediction and
    // stall the output at random.
    always @(posedge clk or negedge rst_n)
    begin
        inverse_t want;
        logic [DW-1:0] got [9];
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_invs.size() == 0)
                begin
                    fails++;
                    $display("%0t: output beat with nothing expected", $realtime);
                end
                else
                begin
                    want = expected_invs.pop_front();
                    got = '{out_ch.e00, out_ch.e01, out_ch.e02, out_ch.e10, out_ch.e11,
                            out_ch.e12, out_ch.e20, out_ch.e21, out_ch.e22};
                    for (int i = 0; i < 9; i++)
                    begin
                        if (got[i] !== want.e[i])
                            report_mismatch($sformatf("inv_r%0dc%0d", i / 3, i % 3),
                                            got[i], want.e[i]);
                    end
                    if (out_ch.singular !== want.singular)
                        report_mismatch("singular", out_ch.singular, want.singular);
                    if (out_ch.saturated !== want.saturated)
                        report_mismatch("saturated", out_ch.saturated, want.saturated);
                end
            end
            if (recv_gap > 0)
            begin
                out_ch.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                out_ch.ready <= 1'b0;
                recv_gap <= $urandom_range(0, 13);
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles in which no beat moves on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_MAX)
        begin
            $display("matrix3x3_inverse_tb NOT OK");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        matrix_t m;
        total_mats = 1000000;

        // Directed: identity, scaled and extreme diagonals, zero and full-scale.
        pending_mats.push_back(diag(ONE, ONE, ONE));
        pending_mats.push_back(diag(-ONE, ONE, -ONE));
        pending_mats.push_back(diag(2 * ONE, ONE / 4, -8 * ONE));
        pending_mats.push_back(diag(1, 1, 1));             // tiny: clips high
        pending_mats.push_back(diag(-1, 1, 1));            // tiny: clips low
        pending_mats.push_back(diag(EMAX, EMAX, EMAX));
        pending_mats.push_back(diag(EMIN, EMIN, EMIN));
        pending_mats.push_back(diag(EMIN, EMAX, ONE));
        pending_mats.push_back(diag('0, '0, '0));          // zero determinant
        m = diag(ONE, ONE, '0);                            // one zero pivot
        pending_mats.push_back(m);
        foreach (m.e[i]) m.e[i] = EMAX;                    // all-equal rows
        pending_mats.push_back(m);
        foreach (m.e[i]) m.e[i] = EMIN;
        pending_mats.push_back(m);
        foreach (m.e[i]) m.e[i] = '1;
        pending_mats.push_back(m);
        // permutation matrix
        m = diag('0, '0, '0);
        m.e[1] = ONE; m.e[5] = ONE; m.e[6] = ONE;
        pending_mats.push_back(m);
        // full-range mix with a first-column expansion that needs wide terms
        m.e = '{EMAX, EMIN, EMAX, EMIN, EMAX, 1, EMAX, -1, EMIN};
        pending_mats.push_back(m);
        m.e = '{ONE, 2 * ONE, 3 * ONE, 0, ONE, 4 * ONE, 5 * ONE, 6 * ONE, 0};
        pending_mats.push_back(m);
        m.e = '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                7 * ONE, 8 * ONE, 9 * ONE};                // singular, nonzero entries
        pending_mats.push_back(m);
        m.e = '{3, -7, 11, 5, 2, -13, 17, 19, -23};        // raw-LSB values
        pending_mats.push_back(m);
        for (int i = 0; i < 3; i++)
            pending_mats.push_back(rand_matrix());

        // Random part; one beat halfway waits for the pipe to drain first.
        for (int i = 0; i < N_RANDOM; i++)
        begin
            m = rand_matrix();
            m.hold_for_drain = (i == N_RANDOM / 2);
            pending_mats.push_back(m);
        end
        total_mats = pending_mats.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_mats.size() == 0 && expected_invs.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);

        if (fails == 0 && expected_invs.size() == 0)
            $display("matrix3x3_inverse_tb OK");
        else
            $display("matrix3x3_inverse_tb NOT OK");
        $finish;
    end
endmodule
